// File: hw/rtl/sfifo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfifo_pkg
// Shared types and constants of the synchronous FIFO with status flags.
// ----------------------------------------------------------------------------
package sfifo_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 13;
  localparam int unsigned DepthW  = 13;

  localparam int unsigned MaxDepthDefault = 4096;

  // APB register map: one 32-bit register, index taken from paddr[2].
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam logic        RegFifoDepth = 1'b0;

  typedef enum logic [OpW-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_COUNT = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_ALMOST_FULL  = 3'd2,
    ST_ALMOST_EMPTY = 3'd3,
    ST_EMPTY        = 3'd4,
    ST_UNDERFLOW    = 3'd5,
    ST_OVERFLOW     = 3'd6,
    ST_UNCONFIGURED = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_e;

  typedef struct packed {
    op_e                     operation;
    logic signed [DataW-1:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_data;
    status_e                 status;
    logic [CountW-1:0]       word_count;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// File: hw/rtl/sync_fifo_with_status_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_fifo_with_status_unit
// FIFO of 32-bit signed words with configurable depth and fill-level status.
// ----------------------------------------------------------------------------
//  Channel   Handshake                          Payload
//  command   start / busy                       cmd_i (operation, write_data)
//  result    result_valid_o (one-cycle strobe)  result_o (read_data, status,
//                                               word_count)
//  config    APB psel/penable/pwrite/pready      fifo_depth at byte address 0
//
// Each command passes through accept, execute against the ring memory,
// then the result strobe; busy is low again in the cycle after the strobe.
// Reset empties the FIFO and leaves it unconfigured (depth 0); the memory
// contents are not cleared. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module sync_fifo_with_status_unit import sfifo_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MaxDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  cmd_t                cmd_i,
  output logic                result_valid_o,
  output result_t             result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [DepthW-1:0] depth_q;
  logic [DepthW-1:0] wr_value;
  logic              reg_sel;
  logic              depth_we;
  ctrl_cmd_t         ctrl;

  assign reg_sel  = (paddr[ApbAddrW-1] == RegFifoDepth);
  assign wr_value = pwdata[DepthW-1:0];
  // Depth values in pwdata[12:0] above the memory size are dropped and the old value stays.
  assign depth_we = psel && penable && pwrite && reg_sel &&
                    (32'(wr_value) <= MAX_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else if (depth_we) begin
      depth_q <= wr_value;
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_sel ? ApbDataW'(depth_q) : '0;

  sfifo_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .ctrl_o         (ctrl)
  );

  sfifo_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cmd_i    (cmd_i),
    .depth_i  (depth_q),
    .result_o (result_o)
  );

endmodule

// File: hw/rtl/sfifo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfifo_ctrl
// Sequencer: accepts a command, runs it through the datapath, strobes result.
// ----------------------------------------------------------------------------
module sfifo_ctrl import sfifo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      result_valid_o,
  output ctrl_cmd_t ctrl_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o         = (state_q != S_IDLE);
    ctrl_o.load    = (state_q == S_IDLE) && start_i;
    ctrl_o.exec    = (state_q == S_EXEC);
    result_valid_o = (state_q == S_RESP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/sfifo_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfifo_datapath
// Ring memory with read and write pointers, fill counter and status logic.
// ----------------------------------------------------------------------------
module sfifo_datapath import sfifo_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MaxDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         ctrl_i,
  input  cmd_t              cmd_i,
  input  logic [DepthW-1:0] depth_i,
  output result_t           result_o
);

  localparam int unsigned PtrW  = $clog2(MAX_DEPTH);
  // The fill level never exceeds the largest depth the register can hold.
  localparam int unsigned FillW = ($clog2(MAX_DEPTH + 1) < CountW) ?
                                  $clog2(MAX_DEPTH + 1) : CountW;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(MAX_DEPTH - 1);

  op_e                     op_q;
  logic [DataW-1:0]        wdata_q;
  logic [PtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [FillW-1:0]        fill_q, fill_d;
  status_e                 status_q, status_d;
  logic [CountW-1:0]       count_q;
  logic                    hit_q, hit_d;
  logic                    mem_we;
  logic [DataW-1:0]        mem [MAX_DEPTH];
  logic [DataW-1:0]        mem_rdata_q;
  logic [CountW-1:0]       fill_ext;
  logic                    is_full;
  logic                    is_empty;

  assign fill_ext = CountW'(fill_q);
  assign is_full  = (fill_ext >= depth_i);
  assign is_empty = (fill_q == '0);

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    status_d = ST_OK;
    hit_d    = 1'b0;
    mem_we   = 1'b0;
    if (depth_i == '0) begin
      status_d = ST_UNCONFIGURED;
    end else begin
      case (op_q)
        OP_WRITE: begin
          if (is_full) begin
            status_d = ST_OVERFLOW;
          end else begin
            mem_we   = 1'b1;
            wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
            fill_d   = fill_q + FillW'(1);
          end
        end
        OP_READ: begin
          if (is_empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            hit_d    = 1'b1;
            rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
            fill_d   = fill_q - FillW'(1);
          end
        end
        OP_COUNT: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else if (fill_q == FillW'(1)) begin
            status_d = ST_ALMOST_EMPTY;
          end else if (fill_ext == depth_i - DepthW'(1)) begin
            status_d = ST_ALMOST_FULL;
          end else if (is_full) begin
            status_d = ST_FULL;
          end
        end
        OP_CLEAR: begin
          status_d = is_empty ? ST_EMPTY : ST_OK;
          rd_ptr_d = '0;
          wr_ptr_d = '0;
          fill_d   = '0;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q    <= cmd_i.operation;
      wdata_q <= cmd_i.write_data;
    end
    if (ctrl_i.exec) begin
      status_q <= status_d;
      count_q  <= CountW'(fill_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
      hit_q    <= 1'b0;
    end else if (ctrl_i.exec) begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      hit_q    <= hit_d;
    end
  end

  // The oldest word is fetched on every executed command; it is only used
  // when the command turns out to be a successful read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && mem_we) begin
      mem[wr_ptr_q] <= wdata_q;
    end
    if (ctrl_i.exec) begin
      mem_rdata_q <= mem[rd_ptr_q];
    end
  end

  assign result_o.read_data  = hit_q ? mem_rdata_q : '0;
  assign result_o.status     = status_q;
  assign result_o.word_count = count_q;

endmodule
